>>> src/aabbct_pkg.sv
// Shared types and constants for the box contact tracker.
package aabbct_pkg;

    // Fixed field widths
    localparam int BODY_W = 6;
    localparam int CMD_W  = 2;
    localparam int EVT_W  = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BODIES = 64;
    localparam int DEF_COORD_BITS = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST   = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEST,
        ST_SWEEP,
        ST_FINISH
    } state_t;

endpackage

>>> src/aabbct_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module aabbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> src/aabbct_overlap.sv
// Strict overlap test of two corner-based boxes.
module aabbct_overlap #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic        [COORD_BITS-2:0] a_w,
    input  logic        [COORD_BITS-2:0] a_h,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic        [COORD_BITS-2:0] b_w,
    input  logic        [COORD_BITS-2:0] b_h,
    output logic                         hit
);

    logic signed [COORD_BITS:0] ax_e, ay_e, bx_e, by_e;
    logic signed [COORD_BITS:0] a_right, a_bottom, b_right, b_bottom;

    // Widen by one bit so the far edges cannot wrap
    always_comb
    begin
        ax_e     = {a_x[COORD_BITS-1], a_x};
        ay_e     = {a_y[COORD_BITS-1], a_y};
        bx_e     = {b_x[COORD_BITS-1], b_x};
        by_e     = {b_y[COORD_BITS-1], b_y};
        a_right  = ax_e + signed'({2'b00, a_w});
        a_bottom = ay_e + signed'({2'b00, a_h});
        b_right  = bx_e + signed'({2'b00, b_w});
        b_bottom = by_e + signed'({2'b00, b_h});
        hit      = (ax_e < b_right) && (a_right > bx_e) &&
                   (ay_e < b_bottom) && (a_bottom > by_e);
    end

endmodule

>>> src/aabb_contact_tracker.sv
// Box contact tracker: overlap test, per-pair contact memory and event reporting.
//
// Each transfer in carries a pair test, a body removal or a wipe of all contacts,
// and each gives exactly one transfer out (event, self id, other id). Contact bits
// live in a MAX_BODIES x MAX_BODIES bit RAM, one row per self body, with a valid
// flop per row so reset and a wipe take effect at once. A pair test reads the self
// row of the RAM, then updates the row and writes it back once the output slot is
// free; a wipe only clears the valid flops. A removal walks through every row of
// the RAM to clear the removed body's column, one row read per cycle and each valid
// row written back. One item is in work at a time; a new item is
// taken while the previous result waits in the output register.
module aabb_contact_tracker #(
    parameter int MAX_BODIES = aabbct_pkg::DEF_MAX_BODIES,
    parameter int COORD_BITS = aabbct_pkg::DEF_COORD_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [aabbct_pkg::CMD_W-1:0]      cmd,
    input  logic [aabbct_pkg::BODY_W-1:0]     body_a,
    input  logic [aabbct_pkg::BODY_W-1:0]     body_b,
    input  logic                              same_owner,
    input  logic signed [COORD_BITS-1:0]      a_x,
    input  logic signed [COORD_BITS-1:0]      a_y,
    input  logic        [COORD_BITS-2:0]      a_w,
    input  logic        [COORD_BITS-2:0]      a_h,
    input  logic signed [COORD_BITS-1:0]      b_x,
    input  logic signed [COORD_BITS-1:0]      b_y,
    input  logic        [COORD_BITS-2:0]      b_w,
    input  logic        [COORD_BITS-2:0]      b_h,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [aabbct_pkg::EVT_W-1:0]      event_res,
    output logic [aabbct_pkg::BODY_W-1:0]     pair_self,
    output logic [aabbct_pkg::BODY_W-1:0]     pair_other
);

    import aabbct_pkg::*;

    localparam int IDX_W = $clog2(MAX_BODIES);
    localparam int CNT_W = $clog2(MAX_BODIES + 1);

    state_t                  state_reg, state_next;
    logic [MAX_BODIES-1:0]   row_valid_reg, row_valid_next;
    logic [IDX_W-1:0]        a_idx_reg, a_idx_next;
    logic [IDX_W-1:0]        b_idx_reg, b_idx_next;
    logic [BODY_W-1:0]       ps_reg, ps_next;
    logic [BODY_W-1:0]       po_reg, po_next;
    logic                    hit_reg, hit_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        sw_row_reg, sw_row_next;
    logic                    sw_wr_reg, sw_wr_next;
    logic                    out_valid_reg, out_valid_next;
    event_t                  event_reg, event_next;
    logic [BODY_W-1:0]       self_reg, self_next;
    logic [BODY_W-1:0]       other_reg, other_next;

    logic                    in_xfer;
    logic                    slot_free;
    logic                    hit;
    logic                    a_in_range, b_in_range;
    logic                    wr_en, rd_en;
    logic [IDX_W-1:0]        wr_addr, rd_addr;
    logic [MAX_BODIES-1:0]   wr_data, rd_data;
    logic [MAX_BODIES-1:0]   row_cur, bit_mask, col_mask;
    logic                    was;
    event_t                  test_event;

    aabbct_overlap #(
        .COORD_BITS (COORD_BITS)
    ) u_overlap (
        .a_x (a_x),
        .a_y (a_y),
        .a_w (a_w),
        .a_h (a_h),
        .b_x (b_x),
        .b_y (b_y),
        .b_w (b_w),
        .b_h (b_h),
        .hit (hit)
    );

    aabbct_ram #(
        .WIDTH (MAX_BODIES),
        .DEPTH (MAX_BODIES)
    ) u_contact_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign a_in_range = (32'(body_a) < MAX_BODIES);
    assign b_in_range = (32'(body_b) < MAX_BODIES);

    assign out_valid  = out_valid_reg;
    assign event_res  = event_reg;
    assign pair_self  = self_reg;
    assign pair_other = other_reg;

    // Decide the pair event from the fetched row
    always_comb
    begin
        row_cur  = row_valid_reg[a_idx_reg] ? rd_data : '0;
        bit_mask = MAX_BODIES'(1) << b_idx_reg;
        col_mask = MAX_BODIES'(1) << a_idx_reg;
        was      = row_cur[b_idx_reg];
        if (hit_reg && was)
        begin
            test_event = EV_STAY;
        end
        else if (hit_reg)
        begin
            test_event = EV_ENTER;
        end
        else if (was)
        begin
            test_event = EV_EXIT;
        end
        else
        begin
            test_event = EV_NONE;
        end
    end

    // Next state, RAM access and result loading
    always_comb
    begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        a_idx_next     = a_idx_reg;
        b_idx_next     = b_idx_reg;
        ps_next        = ps_reg;
        po_next        = po_reg;
        hit_next       = hit_reg;
        cnt_next       = cnt_reg;
        sw_row_next    = sw_row_reg;
        sw_wr_next     = 1'b0;
        event_next     = event_reg;
        self_next      = self_reg;
        other_next     = other_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_en          = 1'b0;
        rd_addr        = IDX_W'(body_a);
        wr_en          = 1'b0;
        wr_addr        = a_idx_reg;
        wr_data        = (row_cur & ~bit_mask) | (hit_reg ? bit_mask : '0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    a_idx_next = IDX_W'(body_a);
                    b_idx_next = IDX_W'(body_b);
                    hit_next   = hit;
                    ps_next    = '0;
                    po_next    = '0;
                    state_next = ST_FINISH;
                    unique case (cmd)
                        CMD_TEST:
                        begin
                            ps_next = body_a;
                            po_next = body_b;
                            if (a_in_range && b_in_range && (body_a != body_b) &&
                                !same_owner)
                            begin
                                // Fetch the self row
                                rd_en      = 1'b1;
                                state_next = ST_TEST;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            ps_next = body_a;
                            if (a_in_range)
                            begin
                                // Drop the row now, walk the column next
                                row_valid_next[IDX_W'(body_a)] = 1'b0;
                                cnt_next   = '0;
                                state_next = ST_SWEEP;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TEST:
            begin
                // Write back the row and report once the output slot is free
                if (slot_free)
                begin
                    wr_en                     = 1'b1;
                    row_valid_next[a_idx_reg] = 1'b1;
                    event_next                = test_event;
                    self_next                 = ps_reg;
                    other_next                = po_reg;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                // Read one row ahead, clear the column bit in the row behind
                if (cnt_reg != CNT_W'(MAX_BODIES))
                begin
                    rd_en       = 1'b1;
                    rd_addr     = IDX_W'(cnt_reg);
                    sw_row_next = IDX_W'(cnt_reg);
                    sw_wr_next  = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
                wr_addr = sw_row_reg;
                wr_data = rd_data & ~col_mask;
                wr_en   = sw_wr_reg && row_valid_reg[sw_row_reg];
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    event_next     = EV_NONE;
                    self_next      = ps_reg;
                    other_next     = po_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            sw_wr_reg     <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
            sw_wr_reg     <= sw_wr_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_idx_reg  <= a_idx_next;
        b_idx_reg  <= b_idx_next;
        ps_reg     <= ps_next;
        po_reg     <= po_next;
        hit_reg    <= hit_next;
        sw_row_reg <= sw_row_next;
        event_reg  <= event_next;
        self_reg   <= self_next;
        other_reg  <= other_next;
    end

`ifndef SYNTH
    // The sweep never reads and writes back the same row in one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("contact RAM read and write collide on one row");

    // A wipe empties every row at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (cmd == CMD_CLEAR)) |=> (row_valid_reg == '0))
    else $error("rows still valid after a wipe");

    // A finished pair test leaves its row valid
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_TEST) && slot_free) |=> row_valid_reg[$past(a_idx_reg)])
    else $error("pair test did not mark its row valid");
`endif

endmodule
